// ----- hw/rtl/ldrl_pkg.sv -----
// ----------------------------------------------------------------------------
// ldrl_pkg
// Shared sizes for the longest distinct run length block.
// ----------------------------------------------------------------------------
package ldrl_pkg;

    localparam int VALUE_BITS  = 16;
    localparam int MAX_LENGTH  = 65536;
    localparam int TABLE_DEPTH = 1 << VALUE_BITS;
    // position counter must hold MAX_LENGTH itself
    localparam int POS_BITS    = $clog2(MAX_LENGTH + 1);
    localparam int IN_BITS     = 16;
    localparam int OUT_BITS    = 17;

    typedef logic [VALUE_BITS-1:0] key_t;
    typedef logic [POS_BITS-1:0]   pos_t;

endpackage

// ----- hw/rtl/longest_distinct_run_length.sv -----
// ----------------------------------------------------------------------------
// longest_distinct_run_length
// Length of the longest run of distinct values in a sequence.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests (value, last) arrive on in_valid / in_stall, one sequence
//   element each; last marks the final element. Only the low VALUE_BITS bits
//   of value key the last-seen table. One request is taken every cycle while a
//   sequence runs: the table read issued at acceptance returns in the next
//   cycle, and a back-to-back hit on the entry just written is forwarded.
//   On the request marked last, the result request (longest) passes through
//   stage 1 into the output register, which holds it valid until taken
//   (out_valid high, out_stall low).
//   After the last element the table is cleared, one entry per cycle, across
//   all 2^VALUE_BITS entries (65536); in_stall stays high during that time. The
//   same clearing pass runs after reset.
//   A last element is held off while an earlier result still waits; other
//   elements keep flowing while the receiver stalls.
//   Elements beyond MAX_LENGTH in one sequence are dropped.
// ----------------------------------------------------------------------------
module longest_distinct_run_length
    import ldrl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [IN_BITS-1:0]  value,
    input  logic                last,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [OUT_BITS-1:0] longest
);

    localparam pos_t MAX_POS   = POS_BITS'(MAX_LENGTH);
    localparam key_t LAST_KEY  = VALUE_BITS'(TABLE_DEPTH - 1);

    pos_t mem [TABLE_DEPTH];

    logic in_accept;
    key_t key;

    logic s1_valid_reg, s1_valid_next;
    logic s1_last_reg;
    key_t s1_key_reg;
    pos_t rd_data_reg;
    logic fwd_hit_reg;
    pos_t fwd_data_reg;

    pos_t position_reg, position_next;
    pos_t window_start_reg, window_start_next;
    pos_t best_length_reg, best_length_next;

    logic clearing_reg, clearing_next;
    key_t clear_cnt_reg, clear_cnt_next;

    logic out_valid_reg, out_valid_next;
    logic [OUT_BITS-1:0] longest_reg;

    logic s1_active;
    pos_t seen;
    pos_t pos_inc;
    pos_t ws_new;
    pos_t run;
    pos_t best_new;

    logic wr_en;
    key_t wr_addr;
    pos_t wr_data;

    assign key       = value[VALUE_BITS-1:0];
    assign in_stall  = clearing_reg || (s1_valid_reg && s1_last_reg) || (last && out_valid_reg);
    assign in_accept = in_valid && !in_stall;

    // stage 1: read-modify-write of the table entry
    always_comb
    begin
        s1_active = s1_valid_reg && (position_reg < MAX_POS);
        seen      = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        pos_inc   = position_reg + pos_t'(1);
        ws_new    = (seen > window_start_reg) ? seen : window_start_reg;
        run       = pos_inc - ws_new;
        best_new  = (run > best_length_reg) ? run : best_length_reg;
    end

    always_comb
    begin
        position_next     = position_reg;
        window_start_next = window_start_reg;
        best_length_next  = best_length_reg;
        if (s1_active)
        begin
            position_next     = pos_inc;
            window_start_next = ws_new;
            best_length_next  = best_new;
        end
        if (s1_valid_reg && s1_last_reg)
        begin
            position_next     = '0;
            window_start_next = '0;
            best_length_next  = '0;
        end
    end

    always_comb
    begin
        clearing_next  = clearing_reg;
        clear_cnt_next = clear_cnt_reg;
        if (clearing_reg)
        begin
            clear_cnt_next = clear_cnt_reg + key_t'(1);
            if (clear_cnt_reg == LAST_KEY)
            begin
                clearing_next = 1'b0;
            end
        end
        else if (s1_valid_reg && s1_last_reg)
        begin
            clearing_next  = 1'b1;
            clear_cnt_next = '0;
        end
    end

    always_comb
    begin
        s1_valid_next  = in_accept;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (s1_valid_reg && s1_last_reg)
        begin
            out_valid_next = 1'b1;
        end
    end

    // single write port: clearing pass or stage 1 update, never both
    always_comb
    begin
        if (clearing_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = clear_cnt_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = s1_active;
            wr_addr = s1_key_reg;
            wr_data = pos_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rd_data_reg  <= mem[key];
            // entry being written this edge would be read stale
            fwd_hit_reg  <= s1_active && (s1_key_reg == key);
            fwd_data_reg <= pos_inc;
            s1_key_reg   <= key;
            s1_last_reg  <= last;
        end
        if (s1_valid_reg && s1_last_reg)
        begin
            longest_reg <= OUT_BITS'(s1_active ? best_new : best_length_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            position_reg     <= '0;
            window_start_reg <= '0;
            best_length_reg  <= '0;
            clearing_reg     <= 1'b1;
            clear_cnt_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            position_reg     <= position_next;
            window_start_reg <= window_start_next;
            best_length_reg  <= best_length_next;
            clearing_reg     <= clearing_next;
            clear_cnt_reg    <= clear_cnt_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign longest   = longest_reg;

endmodule
